/* rtl/lpip_pkg.sv */
package lpip_pkg;

  // Default limits
  localparam int unsigned MAX_ID_LEN_DEF  = 1024;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Character codes
  localparam logic [7:0] CH_NS   = 8'h4E;  // 'N'
  localparam logic [7:0] CH_SEP  = 8'h5F;  // '_'
  localparam logic [7:0] CH_ZERO = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE = 8'h39;  // '9'

  // Fixed result field widths
  localparam int unsigned SEG_W = 11;
  localparam logic [SEG_W-1:0] SEG_MAX = '1;

  typedef enum logic [1:0] {
    PH_DIGITS = 2'd0,
    PH_NS_SEP = 2'd1,
    PH_SKIP   = 2'd2
  } phase_e;

  // Classified character beat, front to back
  typedef struct packed {
    logic       last;
    logic       is_digit;
    logic       is_ns;
    logic       is_sep;
    logic [3:0] digit;
  } char_cls_t;

  // One result beat
  typedef struct packed {
    logic               parse_error;
    logic signed [10:0] node_depth;
    logic [9:0]         meta_start;
    logic               has_parent;
    logic [10:0]        parent_id_length;
    logic [9:0]         parent_ns_start;
    logic [10:0]        parent_ns_length;
  } result_t;

endpackage

/* rtl/lpip_fifo.sv */
module lpip_fifo
  import lpip_pkg::*;
#(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_FULL);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* rtl/lpip_front.sv */
module lpip_front
  import lpip_pkg::*;
(
  input  logic      push_i,
  input  logic [7:0] char_code_i,
  input  logic      last_char_i,
  output logic      full_o,
  output logic      q_push_o,
  output char_cls_t q_data_o,
  input  logic      q_full_i
);

  // Classify each character before it enters the queue
  always_comb begin
    q_data_o.last     = last_char_i;
    q_data_o.is_digit = (char_code_i >= CH_ZERO) && (char_code_i <= CH_NINE);
    q_data_o.is_ns    = (char_code_i == CH_NS);
    q_data_o.is_sep   = (char_code_i == CH_SEP);
    q_data_o.digit    = char_code_i[3:0];
  end

  assign full_o   = q_full_i;
  assign q_push_o = push_i && !q_full_i;

endmodule

/* rtl/lpip_back.sv */
module lpip_back
  import lpip_pkg::*;
#(
  parameter int unsigned MAX_ID_LEN = MAX_ID_LEN_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      beat_valid_i,
  input  char_cls_t beat_i,
  output logic      beat_pop_o,
  input  logic      res_full_i,
  output logic      res_push_o,
  output result_t   res_o
);

  // LEN_W holds MAX_ID_LEN + 1; OFF_W holds an id end offset (up to 2*MAX)
  localparam int unsigned LEN_W = $clog2(MAX_ID_LEN + 2);
  localparam int unsigned OFF_W = $clog2(2 * MAX_ID_LEN + 2);
  localparam int unsigned MUL_W = LEN_W + 4;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_ID_LEN);
  localparam logic [LEN_W-1:0] LEN_SAT = LEN_W'(MAX_ID_LEN + 1);
  localparam logic [MUL_W-1:0] MUL_MAX = MUL_W'(MAX_ID_LEN);

  phase_e             phase_q, phase_s, phase_d;
  logic [LEN_W-1:0]   accum_q, accum_s, accum_d;
  logic               have_dig_q, have_dig_s, have_dig_d;
  logic [LEN_W-1:0]   skip_q, skip_s, skip_d;
  logic [LEN_W-1:0]   pos_q, pos_s, pos_d;
  logic [SEG_W-1:0]   seg_q, seg_s, seg_d;
  logic               nid_v_q, nid_v_s, nid_v_d;
  logic [OFF_W-1:0]   nid_q, nid_s, nid_d;
  logic               lid_v_q, lid_v_s, lid_v_d;
  logic [OFF_W-1:0]   lid_q, lid_s, lid_d;
  logic               lns_v_q, lns_v_s, lns_v_d;
  logic [LEN_W-1:0]   lns_st_q, lns_st_s, lns_st_d;
  logic [LEN_W-1:0]   lns_len_q, lns_len_s, lns_len_d;
  logic               pns_v_q, pns_v_s, pns_v_d;
  logic [LEN_W-1:0]   pns_st_q, pns_st_s, pns_st_d;
  logic [LEN_W-1:0]   pns_len_q, pns_len_s, pns_len_d;
  logic [LEN_W-1:0]   mark_q, mark_s, mark_d;
  logic               err_q, err_s, err_d;
  logic               step;
  logic [MUL_W-1:0]   acc_ext, acc_mul;
  logic               fin_err;
  logic [LEN_W-1:0]   par_st, par_len;
  logic               par_v;

  assign step       = beat_valid_i && (!beat_i.last || !res_full_i);
  assign beat_pop_o = step;
  assign res_push_o = step && beat_i.last;

  assign acc_ext = MUL_W'(accum_q);
  assign acc_mul = (acc_ext << 3) + (acc_ext << 1) + MUL_W'(beat_i.digit);

  // Next state: consume one beat into *_s, then return to reset on last
  always_comb begin
    phase_s    = phase_q;
    accum_s    = accum_q;
    have_dig_s = have_dig_q;
    skip_s     = skip_q;
    pos_s      = pos_q;
    seg_s      = seg_q;
    nid_v_s    = nid_v_q;
    nid_s      = nid_q;
    lid_v_s    = lid_v_q;
    lid_s      = lid_q;
    lns_v_s    = lns_v_q;
    lns_st_s   = lns_st_q;
    lns_len_s  = lns_len_q;
    pns_v_s    = pns_v_q;
    pns_st_s   = pns_st_q;
    pns_len_s  = pns_len_q;
    mark_s     = mark_q;
    err_s      = err_q;

    if (!err_q) begin
      pos_s = pos_q + 1'b1;
      if (pos_q >= LEN_MAX) begin
        err_s = 1'b1;
      end else begin
        unique case (phase_q)
          PH_SKIP: begin
            skip_s = skip_q - 1'b1;
            if (skip_q == LEN_W'(1)) begin
              phase_s = PH_DIGITS;
              if (!beat_i.last) begin
                mark_s = pos_q + 1'b1;
              end
            end
          end
          PH_NS_SEP: begin
            // separator after 'N', any code: open the namespace payload
            mark_s     = pos_q + 1'b1;
            accum_s    = '0;
            have_dig_s = 1'b0;
            skip_s     = accum_q;
            phase_s    = (accum_q == '0) ? PH_DIGITS : PH_SKIP;
          end
          PH_DIGITS: begin
            if (beat_i.is_sep || beat_i.is_ns) begin
              if (!have_dig_q || (accum_q > LEN_MAX)) begin
                err_s = 1'b1;
              end else if (beat_i.is_ns) begin
                pns_v_s   = lns_v_q;
                pns_st_s  = lns_st_q;
                pns_len_s = lns_len_q;
                lns_v_s   = 1'b1;
                lns_st_s  = pos_q + LEN_W'(2);
                lns_len_s = accum_q;
                phase_s   = PH_NS_SEP;
              end else begin
                lid_v_s    = nid_v_q;
                lid_s      = nid_q;
                nid_v_s    = 1'b1;
                nid_s      = OFF_W'(pos_q) + OFF_W'(accum_q) + 1'b1;
                if (seg_q != SEG_MAX) begin
                  seg_s = seg_q + 1'b1;
                end
                mark_s     = pos_q + 1'b1;
                accum_s    = '0;
                have_dig_s = 1'b0;
                skip_s     = accum_q;
                phase_s    = (accum_q == '0) ? PH_DIGITS : PH_SKIP;
              end
            end else if (beat_i.is_digit) begin
              accum_s    = (acc_mul > MUL_MAX) ? LEN_SAT : LEN_W'(acc_mul);
              have_dig_s = 1'b1;
            end else begin
              err_s = 1'b1;
            end
          end
          default: begin
            phase_s = PH_DIGITS;
          end
        endcase
      end
    end

    phase_d    = phase_q;
    accum_d    = accum_q;
    have_dig_d = have_dig_q;
    skip_d     = skip_q;
    pos_d      = pos_q;
    seg_d      = seg_q;
    nid_v_d    = nid_v_q;
    nid_d      = nid_q;
    lid_v_d    = lid_v_q;
    lid_d      = lid_q;
    lns_v_d    = lns_v_q;
    lns_st_d   = lns_st_q;
    lns_len_d  = lns_len_q;
    pns_v_d    = pns_v_q;
    pns_st_d   = pns_st_q;
    pns_len_d  = pns_len_q;
    mark_d     = mark_q;
    err_d      = err_q;
    if (step) begin
      if (beat_i.last) begin
        phase_d    = PH_DIGITS;
        accum_d    = '0;
        have_dig_d = 1'b0;
        skip_d     = '0;
        pos_d      = '0;
        seg_d      = '0;
        nid_v_d    = 1'b0;
        nid_d      = '0;
        lid_v_d    = 1'b0;
        lid_d      = '0;
        lns_v_d    = 1'b0;
        lns_st_d   = '0;
        lns_len_d  = '0;
        pns_v_d    = 1'b0;
        pns_st_d   = '0;
        pns_len_d  = '0;
        mark_d     = '0;
        err_d      = 1'b0;
      end else begin
        phase_d    = phase_s;
        accum_d    = accum_s;
        have_dig_d = have_dig_s;
        skip_d     = skip_s;
        pos_d      = pos_s;
        seg_d      = seg_s;
        nid_v_d    = nid_v_s;
        nid_d      = nid_s;
        lid_v_d    = lid_v_s;
        lid_d      = lid_s;
        lns_v_d    = lns_v_s;
        lns_st_d   = lns_st_s;
        lns_len_d  = lns_len_s;
        pns_v_d    = pns_v_s;
        pns_st_d   = pns_st_s;
        pns_len_d  = pns_len_s;
        mark_d     = mark_s;
        err_d      = err_s;
      end
    end
  end

  // Outputs: result from the post-consume values
  always_comb begin
    fin_err = err_s || (phase_s != PH_DIGITS);
    par_v   = 1'b0;
    par_st  = '0;
    par_len = '0;
    if (lns_v_s && lid_v_s) begin
      if (lid_s < OFF_W'(lns_st_s)) begin
        // latest namespace belongs to the child; parent uses the one before
        if (pns_v_s) begin
          par_v   = 1'b1;
          par_st  = pns_st_s;
          par_len = pns_len_s;
        end
      end else begin
        par_v   = 1'b1;
        par_st  = lns_st_s;
        par_len = lns_len_s;
      end
    end

    res_o = '0;
    if (fin_err) begin
      res_o.parse_error = 1'b1;
    end else begin
      res_o.node_depth = $signed(seg_s - 1'b1);
      res_o.meta_start = 10'(mark_s);
      if (par_v) begin
        res_o.has_parent       = 1'b1;
        res_o.parent_id_length = 11'(lid_s);
        res_o.parent_ns_start  = 10'(par_st);
        res_o.parent_ns_length = 11'(par_len);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_DIGITS;
      accum_q    <= '0;
      have_dig_q <= 1'b0;
      skip_q     <= '0;
      pos_q      <= '0;
      seg_q      <= '0;
      nid_v_q    <= 1'b0;
      nid_q      <= '0;
      lid_v_q    <= 1'b0;
      lid_q      <= '0;
      lns_v_q    <= 1'b0;
      lns_st_q   <= '0;
      lns_len_q  <= '0;
      pns_v_q    <= 1'b0;
      pns_st_q   <= '0;
      pns_len_q  <= '0;
      mark_q     <= '0;
      err_q      <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      accum_q    <= accum_d;
      have_dig_q <= have_dig_d;
      skip_q     <= skip_d;
      pos_q      <= pos_d;
      seg_q      <= seg_d;
      nid_v_q    <= nid_v_d;
      nid_q      <= nid_d;
      lid_v_q    <= lid_v_d;
      lid_q      <= lid_d;
      lns_v_q    <= lns_v_d;
      lns_st_q   <= lns_st_d;
      lns_len_q  <= lns_len_d;
      pns_v_q    <= pns_v_d;
      pns_st_q   <= pns_st_d;
      pns_len_q  <= pns_len_d;
      mark_q     <= mark_d;
      err_q      <= err_d;
    end
  end

endmodule

/* rtl/length_prefixed_id_path_parser.sv */
// Channel  | Handshake          | Beat payload
// ---------+--------------------+-------------------------------------------------
// input    | push / full        | char_code_i, last_char_i
// result   | empty / pop        | parse_error_o, node_depth_o, meta_start_o,
//          |                    | has_parent_o, parent_id_length_o,
//          |                    | parent_ns_start_o, parent_ns_length_o
//
// One character per cycle sustained while no last character waits on a full
// result queue; the length accumulate (x10 + digit) is the longest path.
// Each result is registered in the result queue before it reaches the ports.
// Reset (rst_ni low, asynchronous) empties both queues and restarts the parser.
// Stalls: a full result queue holds back only a last character; the
// character queue then fills and raises full.
module length_prefixed_id_path_parser
  import lpip_pkg::*;
#(
  parameter int unsigned MAX_ID_LEN  = MAX_ID_LEN_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         char_code_i,
  input  logic               last_char_i,
  output logic               empty,
  input  logic               pop,
  output logic               parse_error_o,
  output logic signed [10:0] node_depth_o,
  output logic [9:0]         meta_start_o,
  output logic               has_parent_o,
  output logic [10:0]        parent_id_length_o,
  output logic [9:0]         parent_ns_start_o,
  output logic [10:0]        parent_ns_length_o
);

  // Front end -> character queue
  logic      cq_push, cq_full, cq_empty, cq_pop;
  char_cls_t cq_wdata, cq_rdata;

  // Back end -> result queue
  logic    rq_push, rq_full;
  result_t rq_wdata, rq_rdata;

  // Classify the incoming character
  lpip_front u_front (
    .push_i      (push),
    .char_code_i (char_code_i),
    .last_char_i (last_char_i),
    .full_o      (full),
    .q_push_o    (cq_push),
    .q_data_o    (cq_wdata),
    .q_full_i    (cq_full)
  );

  // Decouples classification from the parse step
  lpip_fifo #(
    .WIDTH ($bits(char_cls_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_char_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cq_push),
    .data_i  (cq_wdata),
    .full_o  (cq_full),
    .pop_i   (cq_pop),
    .data_o  (cq_rdata),
    .empty_o (cq_empty)
  );

  // Parse state and result formation
  lpip_back #(
    .MAX_ID_LEN (MAX_ID_LEN)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_valid_i (!cq_empty),
    .beat_i       (cq_rdata),
    .beat_pop_o   (cq_pop),
    .res_full_i   (rq_full),
    .res_push_o   (rq_push),
    .res_o        (rq_wdata)
  );

  // Result queue: the oldest result sits on the ports until popped
  lpip_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rq_push),
    .data_i  (rq_wdata),
    .full_o  (rq_full),
    .pop_i   (pop),
    .data_o  (rq_rdata),
    .empty_o (empty)
  );

  assign parse_error_o      = rq_rdata.parse_error;
  assign node_depth_o       = rq_rdata.node_depth;
  assign meta_start_o       = rq_rdata.meta_start;
  assign has_parent_o       = rq_rdata.has_parent;
  assign parent_id_length_o = rq_rdata.parent_id_length;
  assign parent_ns_start_o  = rq_rdata.parent_ns_start;
  assign parent_ns_length_o = rq_rdata.parent_ns_length;

endmodule

/* rtl/lpip_checker.sv */
module lpip_checker
  import lpip_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               push,
  input logic               full,
  input logic               last_char_i,
  input logic               empty,
  input logic               pop,
  input logic               parse_error_o,
  input logic signed [10:0] node_depth_o,
  input logic [9:0]         meta_start_o,
  input logic               has_parent_o,
  input logic [10:0]        parent_id_length_o,
  input logic [9:0]         parent_ns_start_o,
  input logic [10:0]        parent_ns_length_o
);

  // Error results carry no other information
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && parse_error_o) |-> (node_depth_o == '0 && meta_start_o == '0 &&
      !has_parent_o && parent_id_length_o == '0))
    else $error("error result with nonzero fields");

  // Parent fields are zero without a parent
  a_no_parent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !has_parent_o) |-> (parent_id_length_o == '0 &&
      parent_ns_start_o == '0 && parent_ns_length_o == '0))
    else $error("parent fields set without parent");

  // A parent needs at least two id segments
  a_parent_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && has_parent_o) |-> (node_depth_o >= 11'sd1))
    else $error("parent reported at depth below one");

  // A waiting result holds until popped
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(meta_start_o) &&
      $stable(node_depth_o) && $stable(parse_error_o)))
    else $error("result changed while waiting");

  // A result can only follow an accepted last character
  a_res_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(empty) && !empty) |-> $past(push && !full && last_char_i, 2) ||
      $past(push && !full && last_char_i, 3) || $past(!empty))
    else $error("result without a last character");

endmodule

bind length_prefixed_id_path_parser lpip_checker u_lpip_checker (.*);

/* verif/length_prefixed_id_path_parser_tb.sv */
module length_prefixed_id_path_parser_tb
  import lpip_pkg::*;
();

  localparam int MAX_LEN      = MAX_ID_LEN_DEF;
  localparam int RANDOM_BEATS = 150;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 400000;

  typedef logic [7:0] char_t;

  logic               clk_i;
  logic               rst_ni;
  logic               push;
  logic               full;
  logic [7:0]         char_code_i;
  logic               last_char_i;
  logic               empty;
  logic               pop;
  logic               parse_error_o;
  logic signed [10:0] node_depth_o;
  logic [9:0]         meta_start_o;
  logic               has_parent_o;
  logic [10:0]        parent_id_length_o;
  logic [9:0]         parent_ns_start_o;
  logic [10:0]        parent_ns_length_o;

  length_prefixed_id_path_parser u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .char_code_i        (char_code_i),
    .last_char_i        (last_char_i),
    .empty              (empty),
    .pop                (pop),
    .parse_error_o      (parse_error_o),
    .node_depth_o       (node_depth_o),
    .meta_start_o       (meta_start_o),
    .has_parent_o       (has_parent_o),
    .parent_id_length_o (parent_id_length_o),
    .parent_ns_start_o  (parent_ns_start_o),
    .parent_ns_length_o (parent_ns_length_o)
  );

  // Expected result beats, oldest first
  result_t pending_results[$];
  int      fail_count;
  int      beats_sent;
  int      burst_left;
  bit      hold_req;
  char_t   path_buf[$];

  // ---------------------------------------------------------------------------
  // Parser shadow state, advanced on every accepted character beat
  // ---------------------------------------------------------------------------
  phase_e      sh_phase;
  int unsigned sh_len_acc;
  int unsigned sh_digits;
  int unsigned sh_skip;
  int unsigned sh_pos;
  int unsigned sh_ids;
  int unsigned sh_mark;
  int          sh_next_id;
  int          sh_last_id;
  int          sh_ns_start;
  int unsigned sh_ns_len;
  int          sh_prev_ns_start;
  int unsigned sh_prev_ns_len;
  bit          sh_bad;

  task automatic clear_parse_state();
    sh_phase         = PH_DIGITS;
    sh_len_acc       = 0;
    sh_digits        = 0;
    sh_skip          = 0;
    sh_pos           = 0;
    sh_ids           = 0;
    sh_mark          = 0;
    sh_next_id       = -1;
    sh_last_id       = -1;
    sh_ns_start      = -1;
    sh_ns_len        = 0;
    sh_prev_ns_start = -1;
    sh_prev_ns_len   = 0;
    sh_bad           = 1'b0;
  endtask

  // Separator seen: payload starts right after it; a zero length goes
  // straight back to length digits.
  task automatic open_payload(int unsigned sep_pos);
    sh_mark = sep_pos + 1;
    if (sh_len_acc == 0) begin
      sh_phase = PH_DIGITS;
    end else begin
      sh_phase = PH_SKIP;
      sh_skip  = sh_len_acc;
    end
    sh_len_acc = 0;
    sh_digits  = 0;
  endtask

  task automatic parse_char(char_t c, logic is_last);
    result_t r;
    bit      parent;
    int      ns_start;
    int      ns_len;
    parent   = 1'b0;
    ns_start = 0;
    ns_len   = 0;
    // once flagged, characters are dropped until the last one
    if (!sh_bad) begin
      if (sh_pos >= MAX_LEN) begin
        sh_bad = 1'b1;  // overlong identifier
      end else begin
        case (sh_phase)
          PH_SKIP: begin
            sh_skip--;
            if (sh_skip == 0) begin
              sh_phase = PH_DIGITS;
              if (!is_last) sh_mark = sh_pos + 1;
            end
          end
          PH_NS_SEP: open_payload(sh_pos);  // any code serves as separator
          default: begin
            if (c == CH_SEP || c == CH_NS) begin
              if (sh_digits == 0 || sh_len_acc > MAX_LEN) begin
                sh_bad = 1'b1;  // empty or oversize length
              end else if (c == CH_NS) begin
                sh_prev_ns_start = sh_ns_start;
                sh_prev_ns_len   = sh_ns_len;
                sh_ns_start      = sh_pos + 2;
                sh_ns_len        = sh_len_acc;
                sh_phase         = PH_NS_SEP;
              end else begin
                sh_last_id = sh_next_id;
                sh_next_id = sh_pos + 1 + sh_len_acc;
                if (sh_ids < 2047) sh_ids++;
                open_payload(sh_pos);
              end
            end else if (c >= CH_ZERO && c <= CH_NINE) begin
              sh_len_acc = sh_len_acc * 10 + (c - CH_ZERO);
              if (sh_len_acc > MAX_LEN) sh_len_acc = MAX_LEN + 1;  // saturate
              if (sh_digits < 15) sh_digits++;
            end else begin
              sh_bad = 1'b1;  // stray character
            end
          end
        endcase
      end
      sh_pos++;
    end
    if (is_last) begin
      // ending after 'N' or inside a payload is a truncated segment
      if (!sh_bad && sh_phase != PH_DIGITS) sh_bad = 1'b1;
      r = '0;
      if (sh_bad) begin
        r.parse_error = 1'b1;
      end else begin
        r.node_depth = 11'(sh_ids - 1);
        r.meta_start = 10'(sh_mark);
        if (sh_ns_start >= 0 && sh_last_id >= 0) begin
          if (sh_last_id < sh_ns_start) begin
            // latest namespace belongs to the child, parent needs an older one
            if (sh_prev_ns_start >= 0) begin
              parent   = 1'b1;
              ns_start = sh_prev_ns_start;
              ns_len   = sh_prev_ns_len;
            end
          end else begin
            parent   = 1'b1;
            ns_start = sh_ns_start;
            ns_len   = sh_ns_len;
          end
        end
        if (parent) begin
          r.has_parent       = 1'b1;
          r.parent_id_length = 11'(sh_last_id);
          r.parent_ns_start  = 10'(ns_start);
          r.parent_ns_length = 11'(ns_len);
        end
      end
      pending_results.push_back(r);
      clear_parse_state();
    end
  endtask

  function automatic string fmt_result(result_t r);
    return $sformatf("err=%0d depth=%0d meta=%0d parent=%0d pid_len=%0d ns=%0d/%0d",
                     r.parse_error, r.node_depth, r.meta_start, r.has_parent,
                     r.parent_id_length, r.parent_ns_start, r.parent_ns_length);
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks result beats, then feeds accepted character beats to the
  // shadow parser. Everything here sees pre-edge values since the testbench
  // only drives at the falling edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        got = {parse_error_o, node_depth_o, meta_start_o, has_parent_o,
               parent_id_length_o, parent_ns_start_o, parent_ns_length_o};
        if (pending_results.size() == 0) begin
          if (fail_count < 10) $display("unexpected result: %s", fmt_result(got));
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (got.parse_error !== want.parse_error ||
              got.node_depth !== want.node_depth ||
              got.meta_start !== want.meta_start ||
              got.has_parent !== want.has_parent ||
              got.parent_id_length !== want.parent_id_length ||
              got.parent_ns_start !== want.parent_ns_start ||
              got.parent_ns_length !== want.parent_ns_length) begin
            if (fail_count < 10) begin
              $display("mismatch exp: %s", fmt_result(want));
              $display("         got: %s", fmt_result(got));
            end
            fail_count++;
          end
        end
      end
      if (push && !full) parse_char(char_code_i, last_char_i);
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: pop pattern changes mode at random intervals (free-flowing
  // down to near-stalled). A hold request forces a long stretch with pop low.
  // ---------------------------------------------------------------------------
  initial begin
    int mode_left;
    int hold_left;
    int pop_pct;
    mode_left = 0;
    hold_left = 0;
    pop_pct   = 100;
    pop       = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        pop <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode_left = $urandom_range(10, 80);
          case ($urandom_range(0, 3))
            0: pop_pct = 100;
            1: pop_pct = 75;
            2: pop_pct = 25;
            default: pop_pct = 5;
          endcase
        end
        mode_left--;
        pop <= ($urandom_range(1, 100) <= pop_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // One character beat. Bursts of random length separated by short gaps; a
  // long burst now and then gives stretches with no idling at all.
  task automatic send_char(char_t c, logic is_last);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap        = $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 12);
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    burst_left--;
    push        <= 1'b1;
    char_code_i <= c;
    last_char_i <= is_last;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic send_path();
    if (path_buf.size() == 0) path_buf.push_back(CH_ZERO);
    foreach (path_buf[i]) send_char(path_buf[i], i == path_buf.size() - 1);
  endtask

  task automatic send_str(string s);
    path_buf.delete();
    foreach (s[i]) path_buf.push_back(s[i]);
    send_path();
  endtask

  task automatic add_num(int v);
    string s;
    s = $sformatf("%0d", v);
    foreach (s[i]) path_buf.push_back(s[i]);
  endtask

  // Sender goes quiet until every expected result has been popped.
  task automatic drain();
    @(negedge clk_i);
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Well-formed path: 1..4 segments, mostly short payloads, some namespaces,
  // random payload bytes, sometimes trailing length digits.
  task automatic build_path();
    int nseg;
    int len;
    path_buf.delete();
    nseg = $urandom_range(1, 4);
    repeat (nseg) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 5);
      if ($urandom_range(0, 5) == 0) path_buf.push_back(CH_ZERO);  // leading zero
      add_num(len);
      if ($urandom_range(0, 2) == 0) begin
        path_buf.push_back(CH_NS);
        path_buf.push_back($urandom_range(0, 1) ? CH_SEP : char_t'($urandom_range(0, 255)));
      end else begin
        path_buf.push_back(CH_SEP);
      end
      repeat (len) path_buf.push_back(char_t'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 7) == 0) add_num($urandom_range(0, 99));
  endtask

  // Break a built path: truncation, a corrupted byte, an empty length, an
  // oversize length, or plain noise.
  task automatic mangle_path();
    string s;
    int    n;
    case ($urandom_range(0, 4))
      0: begin
        if (path_buf.size() > 1) begin
          n = $urandom_range(1, path_buf.size() - 1);
          path_buf = path_buf[0:n-1];
        end
      end
      1: path_buf[$urandom_range(0, path_buf.size() - 1)] = char_t'($urandom_range(0, 255));
      2: path_buf.push_front($urandom_range(0, 1) ? CH_SEP : CH_NS);
      3: begin
        s = $sformatf("%0d", $urandom_range(MAX_LEN + 1, 9999));
        for (int i = s.len() - 1; i >= 0; i--) path_buf.push_front(s[i]);
      end
      default: begin
        path_buf.delete();
        repeat ($urandom_range(1, 8)) path_buf.push_back(char_t'($urandom_range(0, 255)));
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_directed_cases();
    string cases[$];
    cases = '{
      "0_",           // zero-length id segment
      "12",           // trailing digits only: depth -1, meta at 0
      "_",            // empty length before separator
      "N",            // empty length before namespace mark
      "4x",           // stray character in length
      "1025_",        // length one over the limit
      "2N",           // ends right after the namespace mark
      "2_a",          // ends inside a payload
      "1_a12",        // trailing digits after a complete segment
      "1N\377a1_b",   // namespace separator with an arbitrary code
      "1N_a1_b1_c",   // parent found through the latest namespace
      "1_a1N_b1_c",   // namespace belongs to the child, no older one
      "1N_a1_b1N_c1_d"  // child namespace, parent uses the older one
    };
    foreach (cases[i]) send_str(cases[i]);
    drain();
  endtask

  // Identifier one character over the length limit: the final character
  // arrives after the limit and is flagged.
  task automatic test_max_length();
    path_buf.delete();
    add_num(1020);
    path_buf.push_back(CH_SEP);
    repeat (1020) path_buf.push_back(char_t'($urandom_range(0, 255)));
    send_path();
    drain();
  endtask

  // Receiver holds off while short identifiers keep coming: both queues fill
  // and full must hold the sender back.
  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (10) begin
      if ($urandom_range(0, 1)) send_str("0_");
      else begin
        build_path();
        send_path();
      end
    end
    drain();
  endtask

  task automatic test_random_paths();
    int stop_at;
    stop_at = beats_sent + RANDOM_BEATS;
    while (beats_sent < stop_at) begin
      build_path();
      if ($urandom_range(0, 6) == 0) mangle_path();
      send_path();
    end
    drain();
  endtask

  initial begin
    push        = 1'b0;
    char_code_i = '0;
    last_char_i = 1'b0;
    rst_ni      = 1'b0;
    hold_req    = 1'b0;
    fail_count  = 0;
    beats_sent  = 0;
    burst_left  = 0;
    clear_parse_state();
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_cases();
    test_max_length();
    test_backpressure();
    test_random_paths();

    // let any stray beat show up before the verdict
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* length_prefixed_id_path_parser.f */
rtl/lpip_pkg.sv
rtl/lpip_fifo.sv
rtl/lpip_front.sv
rtl/lpip_back.sv
rtl/length_prefixed_id_path_parser.sv
rtl/lpip_checker.sv
verif/length_prefixed_id_path_parser_tb.sv
